FILE: rtl/wdp_pkg.sv
`default_nettype none

package wdp_pkg;

    localparam int STORE_DEPTH = 2048;
    localparam int SAMPLE_BITS = 16;

    // Store address width and a length width that can hold STORE_DEPTH itself.
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int LEN_W  = $clog2(STORE_DEPTH + 1);

    // Fixed field widths of the stream beats.
    localparam int OPCODE_W = 2;
    localparam int TOTAL_W  = 12;
    localparam int INDEX_W  = 11;
    localparam int VALUE_W  = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [SAMPLE_BITS-1:0] wdata;
        logic                   re;
        logic [ADDR_W-1:0]      raddr;
    } ram_cmd_t;

    typedef struct packed {
        logic accepted;
        logic dac_valid;
        logic peak_trigger;
        logic download_active;
    } item_res_t;

endpackage

`default_nettype wire

FILE: rtl/wdp_ram.sv
`default_nettype none

module wdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/wdp_ctrl.sv
`default_nettype none

module wdp_ctrl
    import wdp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic [TOTAL_W-1:0]  total_size,
    input  wire logic [INDEX_W-1:0]  sample_index,
    input  wire logic [VALUE_W-1:0]  sample_value,
    output ram_cmd_t                 ram_cmd,
    output item_res_t                res
);

    logic                   dl_reg, dl_next;
    logic [LEN_W-1:0]       exp_reg, exp_next;
    logic [LEN_W-1:0]       dl_len_reg, dl_len_next;
    logic [LEN_W-1:0]       wave_len_reg, wave_len_next;
    logic [LEN_W-1:0]       play_reg, play_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [ADDR_W-1:0]      peak_pos_reg, peak_pos_next;
    logic                   peak_found_reg, peak_found_next;

    logic [SAMPLE_BITS-1:0] value;
    logic [LEN_W-1:0]       exp_inc;

    assign value   = sample_value[SAMPLE_BITS-1:0];
    assign exp_inc = exp_reg + LEN_W'(1);

    always_comb
    begin
        dl_next         = dl_reg;
        exp_next        = exp_reg;
        dl_len_next     = dl_len_reg;
        wave_len_next   = wave_len_reg;
        play_next       = play_reg;
        max_next        = max_reg;
        peak_pos_next   = peak_pos_reg;
        peak_found_next = peak_found_reg;

        ram_cmd       = '0;
        ram_cmd.waddr = exp_reg[ADDR_W-1:0];
        ram_cmd.wdata = value;
        ram_cmd.raddr = play_reg[ADDR_W-1:0];

        res = '0;

        if (take)
        begin
            unique case (opcode)
                OP_START:
                begin
                    if (!dl_reg && total_size != '0 &&
                        32'(total_size) <= 32'(STORE_DEPTH))
                    begin
                        dl_len_next     = LEN_W'(total_size);
                        exp_next        = '0;
                        max_next        = '0;
                        peak_pos_next   = '0;
                        peak_found_next = 1'b0;
                        dl_next         = 1'b1;
                        res.accepted    = 1'b1;
                    end
                end
                OP_DATA:
                begin
                    if (dl_reg && 32'(sample_index) == 32'(exp_reg) &&
                        32'(exp_reg) < 32'(STORE_DEPTH))
                    begin
                        ram_cmd.we = 1'b1;
                        if (value > max_reg)
                        begin
                            max_next        = value;
                            peak_pos_next   = exp_reg[ADDR_W-1:0];
                            peak_found_next = 1'b1;
                        end
                        exp_next = exp_inc;
                        if (exp_inc >= dl_len_reg)
                        begin
                            dl_next       = 1'b0;
                            wave_len_next = dl_len_reg;
                        end
                        res.accepted = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (!dl_reg)
                    begin
                        // The playback length never exceeds the store, so the
                        // index is always a valid address here.
                        if (play_reg < wave_len_reg)
                        begin
                            ram_cmd.re       = 1'b1;
                            res.dac_valid    = 1'b1;
                            res.peak_trigger = peak_found_reg &&
                                               play_reg == LEN_W'(peak_pos_reg);
                            play_next        = play_reg + LEN_W'(1);
                        end
                        else
                        begin
                            play_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.download_active = dl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_reg         <= 1'b0;
            exp_reg        <= '0;
            dl_len_reg     <= '0;
            wave_len_reg   <= '0;
            play_reg       <= '0;
            max_reg        <= '0;
            peak_pos_reg   <= '0;
            peak_found_reg <= 1'b0;
        end
        else
        begin
            dl_reg         <= dl_next;
            exp_reg        <= exp_next;
            dl_len_reg     <= dl_len_next;
            wave_len_reg   <= wave_len_next;
            play_reg       <= play_next;
            max_reg        <= max_next;
            peak_pos_reg   <= peak_pos_next;
            peak_found_reg <= peak_found_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/waveform_download_and_playback_core.sv
`default_nettype none

// Waveform store with in-order download and per-tick playback. Every input
// beat gives exactly one output beat. The core takes one beat per cycle when
// the output side does not stall. A result is registered in the pending
// stage, where a tick reads the sample store through its single registered
// read port, and then passes an output register that parts the two sides.
// Download writes use the write port in the cycle the beat is accepted, and
// the peak is tracked as samples arrive, so no scan of the store is needed.
// The store has no reset and no clearing pass; only entries written by a
// completed download are ever played.
module waveform_download_and_playback_core
    import wdp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [11:0] total_size, [22:12] sample_index, [38:23] sample_value
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] opcode
    input  wire logic [OPCODE_W-1:0]   s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] accepted, [1] dac_valid, [17:2] dac_code, [18] peak_trigger,
    // [19] download_active
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic                   take;
    logic                   pend_move;
    ram_cmd_t               ram_cmd;
    item_res_t              res;
    logic [SAMPLE_BITS-1:0] rdata;

    logic                   pend_valid_reg, pend_valid_next;
    item_res_t              pend_res_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [VALUE_W-1:0]     dac_code;

    assign take      = s_tvalid && s_tready;
    assign pend_move = pend_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !pend_valid_reg || pend_move;

    wdp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .opcode       (s_tuser),
        .total_size   (s_tdata[11:0]),
        .sample_index (s_tdata[22:12]),
        .sample_value (s_tdata[38:23]),
        .ram_cmd      (ram_cmd),
        .res          (res)
    );

    wdp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .re    (ram_cmd.re),
        .raddr (ram_cmd.raddr),
        .rdata (rdata)
    );

    // Read data holds until the next tick, so a stalled pending beat still
    // sees its own sample.
    assign dac_code = pend_res_reg.dac_valid ? VALUE_W'(rdata) : '0;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (take)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_res_reg <= res;
        end
        if (pend_move)
        begin
            out_data_reg <= {4'b0, pend_res_reg.download_active,
                             pend_res_reg.peak_trigger, dac_code,
                             pend_res_reg.dac_valid, pend_res_reg.accepted};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/wdp_checker.sv
`default_nettype none

module wdp_checker
    import wdp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    // A silent beat carries a zero code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[1]) |-> m_tdata[17:2] == '0)
        else $error("dac_code nonzero without dac_valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[18]) |-> m_tdata[1])
        else $error("peak_trigger without dac_valid");

    // A tick never reports a taken download beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("accepted and dac_valid both set");

    // Playback is paused while a download runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[19]) |-> !m_tdata[1])
        else $error("sample played during download");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

endmodule

bind waveform_download_and_playback_core wdp_checker u_wdp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: sim/waveform_download_and_playback_core_tb.sv
`timescale 1ns / 100ps

module waveform_download_and_playback_core_tb;
    import wdp_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int RAND_ITEMS     = 1560;
    localparam int DRAIN_AT       = 1200;
    localparam int CALM_ITEMS     = 200;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [TOTAL_W-1:0]  total;
        logic [INDEX_W-1:0]  index;
        logic [VALUE_W-1:0]  value;
        logic                drain_first;
    } wave_beat_t;

    typedef struct packed {
        logic               accepted;
        logic               dac_valid;
        logic [VALUE_W-1:0] dac_code;
        logic               peak_trigger;
        logic               download_active;
    } wave_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    waveform_download_and_playback_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    wave_beat_t stim_q[$];
    wave_out_t  expected_out_q[$];

    // Shadow of the waveform store and its control state.
    bit [SAMPLE_BITS-1:0] shadow_store [0:STORE_DEPTH-1];
    bit                   dl_busy;
    bit [LEN_W-1:0]       dl_next;
    bit [LEN_W-1:0]       dl_len;
    bit [LEN_W-1:0]       wave_len;
    bit [LEN_W-1:0]       play_idx;
    bit [SAMPLE_BITS-1:0] run_max;
    bit [ADDR_W-1:0]      peak_pos;
    bit                   peak_ok;

    int  errors;
    int  n_in;
    int  n_out;
    int  n_played;
    int  n_trig;
    int  n_closed;
    int  idle_cycles;
    bit  in_fire;
    bit  drain_next;
    bit  gen_zero;

    function automatic wave_out_t predict_wave_out(wave_beat_t b);
        wave_out_t            r;
        bit [SAMPLE_BITS-1:0] v;
        r = '0;
        v = b.value[SAMPLE_BITS-1:0];
        case (b.op)
            OP_START:
            begin
                if (!dl_busy && b.total != 0 && b.total <= STORE_DEPTH)
                begin
                    dl_len  = b.total;
                    dl_next = '0;
                    run_max = '0;
                    peak_pos = '0;
                    peak_ok = 1'b0;
                    dl_busy = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_DATA:
            begin
                if (dl_busy && LEN_W'(b.index) == dl_next && dl_next < STORE_DEPTH)
                begin
                    shadow_store[dl_next[ADDR_W-1:0]] = v;
                    // Only a strictly larger sample moves the peak, so ties keep the first.
                    if (v > run_max)
                    begin
                        run_max  = v;
                        peak_pos = dl_next[ADDR_W-1:0];
                        peak_ok  = 1'b1;
                    end
                    dl_next = dl_next + LEN_W'(1);
                    if (dl_next >= dl_len)
                    begin
                        dl_busy  = 1'b0;
                        wave_len = dl_len;
                        n_closed++;
                    end
                    r.accepted = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (!dl_busy)
                begin
                    if (play_idx < wave_len && play_idx < STORE_DEPTH)
                    begin
                        r.dac_valid    = 1'b1;
                        r.dac_code     = VALUE_W'(shadow_store[play_idx[ADDR_W-1:0]]);
                        r.peak_trigger = peak_ok && (play_idx == LEN_W'(peak_pos));
                        play_idx       = play_idx + LEN_W'(1);
                    end
                    else
                    begin
                        play_idx = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.download_active = dl_busy;
        return r;
    endfunction

    task automatic queue_beat(logic [OPCODE_W-1:0] op, int total, int index, int value);
        wave_beat_t b;
        b.op          = op;
        b.total       = total[TOTAL_W-1:0];
        b.index       = index[INDEX_W-1:0];
        b.value       = value[VALUE_W-1:0];
        b.drain_first = drain_next;
        drain_next    = 1'b0;
        stim_q.push_back(b);
    endtask

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (gen_zero || r == 0)
            return 0;
        if (r == 1)
            return 16'hFFFF;
        // Small values make equal maxima common.
        if (r <= 3)
            return $urandom_range(0, 3);
        return $urandom_range(0, 65535);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Sender: a beat stays on the bus until it is taken.
    wave_beat_t           cur;
    logic [IN_DATA_W-1:0] in_word;
    int                   gap_left;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (stim_q.size() == 0 ||
                     (stim_q[0].drain_first && expected_out_q.size() != 0))
            begin
                s_tvalid <= 1'b0;
            end
            else if (stim_q.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end
            else
            begin
                cur = stim_q.pop_front();
                in_word = '0;
                in_word[TOTAL_W-1:0]               = cur.total;
                in_word[TOTAL_W +: INDEX_W]         = cur.index;
                in_word[TOTAL_W + INDEX_W +: VALUE_W] = cur.value;
                s_tvalid <= 1'b1;
                s_tuser  <= cur.op;
                s_tdata  <= in_word;
            end
        end
    end

    // Receiver: short random stalls plus one long hold-off that backs up the core.
    int stall_left;
    int hold_left;
    bit hold_done;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (!hold_done && n_out >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (stim_q.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: check result beats first, then predict for the input beat taken now.
    always @(posedge clk)
    begin
        wave_beat_t b;
        wave_out_t  want;
        if (!rst_n)
        begin
            in_fire = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_out++;
                if (expected_out_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result beat with nothing expected, actual %0h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_out_q.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(m_tdata[0]));
                    check_field("dac_valid", 32'(want.dac_valid), 32'(m_tdata[1]));
                    check_field("dac_code", 32'(want.dac_code),
                                32'(m_tdata[2 +: VALUE_W]));
                    check_field("peak_trigger", 32'(want.peak_trigger),
                                32'(m_tdata[VALUE_W + 2]));
                    check_field("download_active", 32'(want.download_active),
                                32'(m_tdata[VALUE_W + 3]));
                    check_field("padding", 0, 32'(m_tdata[OUT_DATA_W-1:VALUE_W + 4]));
                    if (want.dac_valid)
                        n_played++;
                    if (want.peak_trigger)
                        n_trig++;
                end
            end
            in_fire = s_tvalid && s_tready;
            if (in_fire)
            begin
                n_in++;
                b.op          = s_tuser;
                b.total       = s_tdata[TOTAL_W-1:0];
                b.index       = s_tdata[TOTAL_W +: INDEX_W];
                b.value       = s_tdata[TOTAL_W + INDEX_W +: VALUE_W];
                b.drain_first = 1'b0;
                expected_out_q.push_back(predict_wave_out(b));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no beat moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_out_q.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        int gen_len;
        int gen_next;
        bit gen_busy;
        bit drain_mark;

        gen_busy = 1'b0;
        drain_mark = 1'b0;
        gen_zero = 1'b0;

        // Directed: empty playback, unused opcode, refusals, ties, wrap, all-zero waveform.
        queue_beat(OP_TICK, 0, 0, 0);
        queue_beat(OP_UNUSED, 0, 0, 0);
        queue_beat(OP_DATA, 0, 0, 16'h1234);
        queue_beat(OP_START, 0, 0, 0);
        queue_beat(OP_START, 4095, 0, 0);
        queue_beat(OP_START, STORE_DEPTH + 1, 0, 0);
        queue_beat(OP_START, 3, 0, 0);
        queue_beat(OP_START, 5, 0, 0);
        queue_beat(OP_TICK, 0, 0, 0);
        queue_beat(OP_DATA, 0, 1, 16'h5555);
        queue_beat(OP_DATA, 0, 0, 16'hFFFF);
        queue_beat(OP_DATA, 0, 1, 16'hFFFF);
        queue_beat(OP_DATA, 0, 2, 0);
        repeat (4) queue_beat(OP_TICK, 0, 0, 0);
        queue_beat(OP_START, 2, 0, 0);
        queue_beat(OP_DATA, 0, 0, 0);
        queue_beat(OP_DATA, 0, 1, 0);
        repeat (3) queue_beat(OP_TICK, 0, 0, 0);
        queue_beat(OP_UNUSED, 4095, 2047, 16'hFFFF);
        queue_beat(OP_DATA, 4095, 2047, 16'hFFFF);

        drain_next = 1'b1;
        while (stim_q.size() < RAND_ITEMS || gen_busy)
        begin
            if (stim_q.size() >= DRAIN_AT && !drain_mark)
            begin
                drain_mark = 1'b1;
                drain_next = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (gen_busy)
            begin
                if (r < 85)
                begin
                    queue_beat(OP_DATA, $urandom_range(0, 4095), gen_next, pick_value());
                    gen_next++;
                    if (gen_next >= gen_len)
                        gen_busy = 1'b0;
                end
                else if (r < 90)
                    queue_beat(OP_START, $urandom_range(0, 4095), $urandom_range(0, 2047),
                               $urandom_range(0, 65535));
                else if (r < 94)
                    queue_beat(OP_TICK, $urandom_range(0, 4095), $urandom_range(0, 2047),
                               $urandom_range(0, 65535));
                else if (r < 97)
                    queue_beat(OP_DATA, $urandom_range(0, 4095),
                               gen_next ^ (1 << $urandom_range(0, INDEX_W - 1)),
                               $urandom_range(0, 65535));
                else
                    queue_beat(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 2047),
                               $urandom_range(0, 65535));
            end
            else
            begin
                if (r < 14)
                begin
                    if ($urandom_range(0, 9) == 0)
                        gen_len = $urandom_range(25, 160);
                    else
                        gen_len = $urandom_range(1, 24);
                    gen_zero = ($urandom_range(0, 9) == 0);
                    queue_beat(OP_START, gen_len, $urandom_range(0, 2047),
                               $urandom_range(0, 65535));
                    gen_busy = 1'b1;
                    gen_next = 0;
                end
                else if (r < 19)
                    queue_beat(OP_START,
                               ($urandom_range(0, 3) == 0) ? 0 :
                               $urandom_range(STORE_DEPTH + 1, 4095),
                               $urandom_range(0, 2047), $urandom_range(0, 65535));
                else if (r < 24)
                    queue_beat(OP_DATA, $urandom_range(0, 4095), $urandom_range(0, 2047),
                               $urandom_range(0, 65535));
                else if (r < 26)
                    queue_beat(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 2047),
                               $urandom_range(0, 65535));
                else
                    queue_beat(OP_TICK, $urandom_range(0, 4095), $urandom_range(0, 2047),
                               $urandom_range(0, 65535));
            end
        end

        // A start of exactly the store depth is legal; that download stays open to the end.
        queue_beat(OP_START, STORE_DEPTH, 0, 0);
        queue_beat(OP_DATA, 0, 0, 16'h8000);
        queue_beat(OP_DATA, 0, 1, 16'h8000);
        queue_beat(OP_TICK, 0, 0, 0);
        queue_beat(OP_START, 7, 0, 0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid || expected_out_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d input beats and %0d result beats, %0d downloads completed.",
                 n_in, n_out, n_closed);
        $display("Playback wrote %0d samples to the DAC and fired %0d peak triggers.",
                 n_played, n_trig);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
